FILE: rtl/three_axis_iir_bandpass_with_reject_unit_macros.svh
// Assertion macros for the checker file.
`ifndef THREE_AXIS_IIR_BANDPASS_WITH_REJECT_UNIT_MACROS_SVH
`define THREE_AXIS_IIR_BANDPASS_WITH_REJECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRBP_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIRBP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/iirbp_pkg.sv
package iirbp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int NUM_AXES   = 3;

    // Products are COEF_W + SAMPLE_W bits; five of them need three guard bits.
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 3;

    localparam int DEF_COEF_FRAC_BITS = 14;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT = 3'd5;

    // Reset values: a band-pass around the sensor's motion band.
    localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 18'sd1838;
    localparam logic signed [COEF_W-1:0] RST_COEF_B1 = 18'sd0;
    localparam logic signed [COEF_W-1:0] RST_COEF_B2 = -18'sd1838;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1 = 18'sd28805;
    localparam logic signed [COEF_W-1:0] RST_COEF_A2 = -18'sd12709;
    localparam logic [LIMIT_W-1:0]       RST_REJECT_LIMIT = 15'd10000;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

endpackage

FILE: rtl/three_axis_iir_bandpass_with_reject_unit.sv
// An input transaction reaches m_axis through the input register, then the
// filter arithmetic into the result register.
// Throughput: one transaction per cycle unless m_axis_tready stalls the result; each axis has five parallel
// multipliers and updates its history, unless rejected, in the same cycle as the result register.
// Reset (aresetn low, synchronous): pipeline emptied, filter history zeroed,
// coefficients and reject limit return to their default band-pass values.
module three_axis_iir_bandpass_with_reject_unit
    import iirbp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,   // sample_x, sample_y, sample_z

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // filtered_x, filtered_y, filtered_z
    output logic [2:0]            m_axis_tuser,   // rejected_x, rejected_y, rejected_z

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ---------------------------------------------------------------------
    // Configuration registers. Write them only while no transaction is in
    // flight; the filters read them directly.
    // ---------------------------------------------------------------------
    coef_set_t            coefs_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.b0 <= RST_COEF_B0;
            coefs_reg.b1 <= RST_COEF_B1;
            coefs_reg.b2 <= RST_COEF_B2;
            coefs_reg.a1 <= RST_COEF_A1;
            coefs_reg.a2 <= RST_COEF_A2;
            limit_reg    <= RST_REJECT_LIMIT;
        end else if (cfg_wr_en) begin
            // Drop writes to indexes past the register list.
            unique case (cfg_index)
                REG_COEF_B0:      coefs_reg.b0 <= cfg_wdata;
                REG_COEF_B1:      coefs_reg.b1 <= cfg_wdata;
                REG_COEF_B2:      coefs_reg.b2 <= cfg_wdata;
                REG_COEF_A1:      coefs_reg.a1 <= cfg_wdata;
                REG_COEF_A2:      coefs_reg.a2 <= cfg_wdata;
                REG_REJECT_LIMIT: limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake. The result register frees when it is empty or being taken;
    // the input register moves into it whenever it frees, so a new input
    // transaction is taken every cycle unless both stages are full and the result is stalled.
    // ---------------------------------------------------------------------
    logic        in_valid_reg;
    logic [47:0] in_data_reg;
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [2:0]  out_flags_reg;
    logic        out_free;
    logic        advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Hold the payload whenever the stage is stalled.
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // ---------------------------------------------------------------------
    // One filter per axis; each owns its own x and y history.
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] filt [NUM_AXES];
    logic [NUM_AXES-1:0]        rej;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        iirbp_axis #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_axis (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (advance),
            .sample       (in_data_reg[a*SAMPLE_W +: SAMPLE_W]),
            .coefs        (coefs_reg),
            .reject_limit (limit_reg),
            .filtered     (filt[a]),
            .rejected     (rej[a])
        );
    end

    // ---------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg  <= {filt[2], filt[1], filt[0]};
            out_flags_reg <= rej;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

FILE: rtl/iirbp_axis.sv
module iirbp_axis
    import iirbp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  coef_set_t                  coefs,
    input  logic [LIMIT_W-1:0]         reject_limit,
    output logic signed [SAMPLE_W-1:0] filtered,
    output logic                       rejected
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);
    localparam logic [ACC_W-1:0] FRAC_MASK =
        (ACC_W'(1) << COEF_FRAC_BITS) - ACC_W'(1);

    logic signed [SAMPLE_W-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [SAMPLE_W:0]   s_ext;
    logic [SAMPLE_W:0]          mag;
    logic signed [PROD_W-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    quot;
    logic                       frac_nz;
    logic signed [SAMPLE_W-1:0] y_new;

    // Reject on magnitude; the most negative code always lands above any limit.
    assign s_ext    = (SAMPLE_W + 1)'(sample);
    assign mag      = s_ext[SAMPLE_W] ? $unsigned(-s_ext) : $unsigned(s_ext);
    assign rejected = mag > {2'b00, reject_limit};

    assign p_b0 = coefs.b0 * sample;
    assign p_b1 = coefs.b1 * x1_reg;
    assign p_b2 = coefs.b2 * x2_reg;
    assign p_a1 = coefs.a1 * y1_reg;
    assign p_a2 = coefs.a2 * y2_reg;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               + ACC_W'(p_a1) + ACC_W'(p_a2);

    // Arithmetic shift floors; bump negative values with a remainder to truncate toward zero.
    assign frac_nz = |($unsigned(acc) & FRAC_MASK);
    assign quot    = (acc >>> COEF_FRAC_BITS)
                   + $signed(ACC_W'(acc[ACC_W-1] && frac_nz));

    always_comb begin
        if (quot > SAT_MAX) begin
            y_new = 16'sh7fff;
        end else if (quot < SAT_MIN) begin
            y_new = -16'sh8000;
        end else begin
            y_new = quot[SAMPLE_W-1:0];
        end
    end

    assign filtered = rejected ? y1_reg : y_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (advance && !rejected) begin
            x1_reg <= sample;
            x2_reg <= x1_reg;
            y1_reg <= y_new;
            y2_reg <= y1_reg;
        end
    end

endmodule

FILE: rtl/iirbp_checker.sv
`include "three_axis_iir_bandpass_with_reject_unit_macros.svh"

module iirbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result keeps its data and flags.
    `IIRBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Input back-pressure only comes from a full, stalled result register.
    `IIRBP_ASSERT_NOW(a_stall_source, aclk, aresetn, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

    // Accepted data shows m_axis_tvalid after input and result registers.
    `IIRBP_ASSERT_NOW(a_latency, aclk, aresetn, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid, "no result two cycles after input")

endmodule

bind three_axis_iir_bandpass_with_reject_unit iirbp_checker u_iirbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/three_axis_iir_bandpass_with_reject_unit_tb.sv
`timescale 1ns / 1ps

module three_axis_iir_bandpass_with_reject_unit_tb;
    import iirbp_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int FRAC_BITS   = DEF_COEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 200;

    // Indexes past the last register; writes there must leave the filter alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [NUM_AXES-1:0] rejected;
        sample_t             fz;
        sample_t             fy;
        sample_t             fx;
    } filt_result_t;

    // Tracks coefficients, reject limit and per-axis history, and holds the
    // filtered triples still owed by the block, oldest first.
    class iir_result_scoreboard;
        logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
        logic [LIMIT_W-1:0]       reject_limit;
        sample_t                  raw_hist[6];
        sample_t                  out_hist[6];
        filt_result_t             owed_results[$];
        int unsigned              errors;

        function new();
            b0 = RST_COEF_B0;
            b1 = RST_COEF_B1;
            b2 = RST_COEF_B2;
            a1 = RST_COEF_A1;
            a2 = RST_COEF_A2;
            reject_limit = RST_REJECT_LIMIT;
            foreach (raw_hist[i]) begin
                raw_hist[i] = '0;
                out_hist[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COEF_B0:      b0 = data[COEF_W-1:0];
                REG_COEF_B1:      b1 = data[COEF_W-1:0];
                REG_COEF_B2:      b2 = data[COEF_W-1:0];
                REG_COEF_A1:      a1 = data[COEF_W-1:0];
                REG_COEF_A2:      a2 = data[COEF_W-1:0];
                REG_REJECT_LIMIT: reject_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // One axis of the biquad; returns 1 when the sample is rejected.
        function bit filter_axis(int axis, sample_t s, output sample_t r);
            longint mag;
            longint acc;
            longint q;
            mag = (s < 0) ? -longint'(s) : longint'(s);
            if (mag > longint'(reject_limit)) begin
                r = out_hist[2*axis];
                return 1'b1;
            end
            acc = longint'(b0) * longint'(s)
                + longint'(b1) * longint'(raw_hist[2*axis])
                + longint'(b2) * longint'(raw_hist[2*axis+1])
                + longint'(a1) * longint'(out_hist[2*axis])
                + longint'(a2) * longint'(out_hist[2*axis+1]);
            // truncate toward zero, then clamp to 16 bits
            if (acc < 0)
                q = -((-acc) >>> FRAC_BITS);
            else
                q = acc >>> FRAC_BITS;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            r = q[SAMPLE_W-1:0];
            raw_hist[2*axis+1] = raw_hist[2*axis];
            raw_hist[2*axis]   = s;
            out_hist[2*axis+1] = out_hist[2*axis];
            out_hist[2*axis]   = r;
            return 1'b0;
        endfunction

        function void note_sample(sample_t sx, sample_t sy, sample_t sz);
            filt_result_t e;
            sample_t rx, ry, rz;
            e.rejected[0] = filter_axis(0, sx, rx);
            e.rejected[1] = filter_axis(1, sy, ry);
            e.rejected[2] = filter_axis(2, sz, rz);
            e.fx = rx;
            e.fy = ry;
            e.fz = rz;
            owed_results.push_back(e);
        endfunction

        function void check_result(logic [47:0] data, logic [2:0] user);
            filt_result_t e;
            if (owed_results.size() == 0) begin
                $error("unexpected result: tdata %h tuser %b", data, user);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (data[15:0] !== e.fx) begin
                $error("filtered_x: expected %0d, actual %0d", e.fx, $signed(data[15:0]));
                errors++;
            end
            if (data[31:16] !== e.fy) begin
                $error("filtered_y: expected %0d, actual %0d", e.fy, $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== e.fz) begin
                $error("filtered_z: expected %0d, actual %0d", e.fz, $signed(data[47:32]));
                errors++;
            end
            if (user[0] !== e.rejected[0]) begin
                $error("rejected_x: expected %0b, actual %0b", e.rejected[0], user[0]);
                errors++;
            end
            if (user[1] !== e.rejected[1]) begin
                $error("rejected_y: expected %0b, actual %0b", e.rejected[1], user[1]);
                errors++;
            end
            if (user[2] !== e.rejected[2]) begin
                $error("rejected_z: expected %0b, actual %0b", e.rejected[2], user[2]);
                errors++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;   // sample_x, sample_y, sample_z
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // filtered_x, filtered_y, filtered_z
    logic [2:0]            m_axis_tuser;   // rejected_x, rejected_y, rejected_z
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    iir_result_scoreboard iir_sb;
    bit                   no_idle;
    int unsigned          stall_left;
    int unsigned          cycle_count;

    three_axis_iir_bandpass_with_reject_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    // Bail out if the block hangs; even the slowest legal run ends far earlier.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Compare every result transaction against the oldest owed triple.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            iir_sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Back-pressure on the result side: mostly short stalls, a few long ones;
    // while no_idle is set no new stall starts, though a running one finishes.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            m_axis_tready = 1'b0;
            if ($urandom_range(0, 99) < 85)
                stall_left = $urandom_range(0, 2);
            else
                stall_left = $urandom_range(9, 39);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Idle cycles between input transactions, shaped like the result stalls.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly in-band samples so the history keeps evolving; the rest sit on
    // the reject boundary, span the full 16 bits, or hit the extremes or zero.
    function automatic sample_t make_sample();
        int lim;
        int v;
        int unsigned r;
        lim = int'(iir_sb.reject_limit);
        r = $urandom_range(0, 99);
        if (r < 65) begin
            v = int'($urandom_range(0, 2 * lim)) - lim;
        end else if (r < 77) begin
            case ($urandom_range(0, 3))
                0: v = lim;
                1: v = -lim;
                2: v = lim + 1;
                default: v = -lim - 1;
            endcase
        end else if (r < 95) begin
            v = int'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 2))
                0: v = 32767;
                1: v = -32768;
                default: v = 0;
            endcase
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int v;
        if ($urandom_range(0, 3) == 0)
            return COEF_W'($urandom());
        v = int'($urandom_range(0, 40000)) - 20000;
        return v[COEF_W-1:0];
    endfunction

    // Present one sample triple, hold it until accepted, then idle for the gap that pick_gap chooses.
    task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
        int unsigned gap;
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {sz, sy, sx};
        forever begin
            @(posedge aclk);
            if (s_axis_tready)
                break;
        end
        iir_sb.note_sample(sx, sy, sz);
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {16'($urandom()), 32'($urandom())};
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic run_random(input int count);
        sample_t sx, sy, sz;
        repeat (count) begin
            sx = make_sample();
            sy = make_sample();
            sz = make_sample();
            send_sample(sx, sy, sz);
        end
    endtask

    // Drop valid and wait until every owed result has been collected.
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (iir_sb.owed() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        iir_sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Load a full filter setting; the limit write carries junk in its upper
    // bits, and a stray write to an unused index follows.
    task automatic set_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                              input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                              input logic [COEF_W-1:0] a2, input logic [LIMIT_W-1:0] lim);
        write_reg(REG_COEF_B0, b0);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
        write_reg(REG_REJECT_LIMIT, {3'($urandom_range(0, 7)), lim});
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom()));
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        no_idle       = 1'b0;
        stall_left    = 0;
        cycle_count   = 0;
        iir_sb = new();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset band-pass, limit 10000. Rejects straight after reset
        // must repeat zero; boundary magnitudes pass; -32768 always rejects.
        send_sample(16'sd10001, -16'sd10001, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd10000, -16'sd10000, 16'sd10000);
        send_sample(16'sd32767, -16'sd32768, -16'sd1);
        send_sample(-16'sd32768, 16'sd32767, 16'sd1);
        send_sample(16'sd10000, 16'sd10000, -16'sd10000);
        send_sample(-16'sd10000, -16'sd10000, 16'sd10000);
        send_sample(16'sd10001, 16'sd10000, -16'sd10001);
        send_sample(16'sd1234, -16'sd2345, 16'sd3456);
        send_sample(16'h5555, 16'sh2AAA, -16'sd9999);
        send_sample(16'sd9999, 16'sd1, -16'sd1);
        repeat (6)
            send_sample(16'sd10000, -16'sd10000, 16'sd5000);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd0);

        // Random traffic on the reset setting.
        run_random(PHASE_ITEMS);

        for (int p = 0; p < 7; p++) begin
            drain_results();
            no_idle = (p == 4);
            case (p)
                0: set_filter(18'sd131071, -18'sd131072, 18'sd131071,
                              -18'sd131072, 18'sd131071, 15'd32767);
                1: set_filter(-18'sd131072, 18'sd131071, -18'sd131072,
                              18'sd131071, -18'sd131072, 15'd32767);
                2: set_filter(rand_coef(), rand_coef(), rand_coef(),
                              rand_coef(), rand_coef(), 15'd0);
                // pass-through with negative feedback: y = x - y1
                5: set_filter(18'sd16384, 18'sd0, 18'sd0, -18'sd16384, 18'sd0,
                              LIMIT_W'($urandom_range(0, 32767)));
                6: set_filter(RST_COEF_B0, RST_COEF_B1, RST_COEF_B2,
                              RST_COEF_A1, RST_COEF_A2, 15'd32767);
                default: set_filter(rand_coef(), rand_coef(), rand_coef(),
                                    rand_coef(), rand_coef(),
                                    LIMIT_W'($urandom_range(0, 32767)));
            endcase
            run_random(PHASE_ITEMS);
        end

        drain_results();
        no_idle = 1'b0;
        // Keep the clock running to catch any stray result after the last one.
        repeat (4) @(posedge aclk);
        if (iir_sb.errors == 0 && iir_sb.owed() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
